### rtl/core/stip_pkg.sv
// stip_pkg: shared types, character codes and limits for the string-to-int64 parser.
// Used by the channel interfaces, controller, datapath and top level.
package stip_pkg;

   localparam int CHAR_W  = 8;
   localparam int BASE_W  = 6;
   localparam int VALUE_W = 64;
   localparam int END_W   = 13;
   localparam int DIGIT_W = 6;
   localparam int PROD_W  = VALUE_W + BASE_W;
   localparam int SUM_W   = PROD_W + 1;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'd65;
   localparam logic [CHAR_W-1:0] CHAR_UP_X  = 8'd88;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'd90;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'd97;
   localparam logic [CHAR_W-1:0] CHAR_LO_X  = 8'd120;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'd122;
   localparam logic [CHAR_W-1:0] UP_OFFSET  = 8'd55;   // 'A' - 10
   localparam logic [CHAR_W-1:0] LO_OFFSET  = 8'd87;   // 'a' - 10

   localparam logic [SUM_W-1:0] LIMIT_POS = {7'd0, 1'b0, {63{1'b1}}};
   localparam logic [SUM_W-1:0] LIMIT_NEG = {7'd0, 1'b1, {63{1'b0}}};
   localparam logic [VALUE_W-1:0] SAT_POS = {1'b0, {63{1'b1}}};
   localparam logic [VALUE_W-1:0] SAT_NEG = {1'b1, {63{1'b0}}};

   typedef enum logic [2:0] {
      PH_WS,
      PH_SIGN,
      PH_ZERO,
      PH_HEX,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_NONE,
      ST_SEEN,
      ST_OVER
   } status_type;

   typedef enum logic {
      CT_IDLE,
      CT_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic slot_free;
   } sts_type;

   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] value;
   } digit_type;

   function automatic digit_type digit_value(input logic [CHAR_W-1:0] c);
      digit_type r;
      r.valid = 1'b1;
      r.value = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r.value = DIGIT_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         r.value = DIGIT_W'(c - UP_OFFSET);
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         r.value = DIGIT_W'(c - LO_OFFSET);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE;
   endfunction

endpackage

### rtl/core/stip_req_if.sv
// stip_req_if: input channel of the parser, one string byte per item.
// Depends on stip_pkg for field widths.
interface stip_req_if;
   logic                         valid;
   logic                         ready;
   logic [stip_pkg::CHAR_W-1:0]  char_code;
   logic                         last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

### rtl/core/stip_rsp_if.sv
// stip_rsp_if: result channel of the parser, one converted number per item.
// Depends on stip_pkg for field widths.
interface stip_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [stip_pkg::VALUE_W-1:0] value;
   logic                                overflow;
   logic [stip_pkg::END_W-1:0]          end_offset;

   modport source (output valid, output value, output overflow, output end_offset,
                   input ready);
   modport sink   (input valid, input value, input overflow, input end_offset,
                   output ready);
endinterface

### rtl/core/stip_csr_if.sv
// stip_csr_if: write channel for the base_setting register.
// Depends on stip_pkg for the register width.
interface stip_csr_if;
   logic                         valid;
   logic                         ready;
   logic [stip_pkg::BASE_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/stip_ctrl.sv
// stip_ctrl: handshake sequencer; latches a byte, then commits its step in execute.
// Depends on stip_pkg for the state, command and status types.
module stip_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  stip_pkg::sts_type  sts,
   output stip_pkg::cmd_type  cmd
);

   stip_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stip_pkg::CT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stip_pkg::CT_IDLE: begin
            if (req_valid) state_in = stip_pkg::CT_EXEC;
         end
         stip_pkg::CT_EXEC: begin
            if (!sts.emit || sts.slot_free) state_in = stip_pkg::CT_IDLE;
         end
         default: state_in = stip_pkg::CT_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         stip_pkg::CT_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         stip_pkg::CT_EXEC: begin
            cmd.commit = !sts.emit || sts.slot_free;
         end
         default: ;
      endcase
   end

endmodule

### rtl/core/stip_dpath.sv
// stip_dpath: parse state, digit accumulator with registered multiply, base register
// and result register. Depends on stip_pkg; driven by stip_ctrl commands.
module stip_dpath #(
   parameter int MAX_LEN = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stip_pkg::cmd_type                   cmd,
   output stip_pkg::sts_type                   sts,
   input  logic [stip_pkg::CHAR_W-1:0]         char_code,
   input  logic                                last,
   input  logic                                csr_write,
   input  logic [stip_pkg::BASE_W-1:0]         csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [stip_pkg::VALUE_W-1:0] rsp_value,
   output logic                                rsp_overflow,
   output logic [stip_pkg::END_W-1:0]          rsp_end_offset
);

   localparam int PosW = $clog2(MAX_LEN + 1);
   localparam int EndW = (PosW + 1 > stip_pkg::END_W) ? PosW + 1 : stip_pkg::END_W;
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_LEN);

   logic [stip_pkg::BASE_W-1:0]  cfg_base_ff;
   logic [stip_pkg::CHAR_W-1:0]  char_ff;
   logic                         last_ff;
   logic [stip_pkg::PROD_W-1:0]  prod_ff;

   stip_pkg::phase_type          phase_ff, phase_in;
   stip_pkg::status_type         status_ff, status_in;
   logic                         neg_ff, neg_in;
   logic [stip_pkg::BASE_W-1:0]  base_ff, base_in;
   logic [stip_pkg::VALUE_W-1:0] acc_ff, acc_in;
   logic [PosW-1:0]              pos_ff, pos_in;

   logic                         out_valid_ff, out_valid_in;
   logic [stip_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic                         out_over_ff, out_over_in;
   logic [stip_pkg::END_W-1:0]   out_end_ff, out_end_in;

   stip_pkg::digit_type          dig;
   logic [stip_pkg::SUM_W-1:0]   sum;
   logic [stip_pkg::SUM_W-1:0]   limit;
   logic                         over;
   logic                         first;
   logic                         take;
   logic [stip_pkg::BASE_W-1:0]  take_base;
   logic [stip_pkg::BASE_W-1:0]  first_base;
   logic                         emit;
   logic [EndW-1:0]              end_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff <= stip_pkg::BASE_RESET;
      end else if (csr_write) begin
         cfg_base_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff <= char_code;
         last_ff <= last;
      end
      prod_ff <= stip_pkg::PROD_W'(acc_ff) * stip_pkg::PROD_W'(base_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= stip_pkg::PH_WS;
         status_ff <= stip_pkg::ST_NONE;
         neg_ff    <= 1'b0;
         base_ff   <= '0;
         acc_ff    <= '0;
         pos_ff    <= '0;
      end else if (cmd.commit) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         neg_ff    <= neg_in;
         base_ff   <= base_in;
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (cmd.commit && emit) begin
         out_value_ff <= out_value_in;
         out_over_ff  <= out_over_in;
         out_end_ff   <= out_end_in;
      end
   end

   assign dig   = stip_pkg::digit_value(char_ff);
   assign sum   = {1'b0, prod_ff} + stip_pkg::SUM_W'(dig.value);
   assign limit = neg_ff ? stip_pkg::LIMIT_NEG : stip_pkg::LIMIT_POS;
   assign over  = sum > limit;
   assign first_base = (cfg_base_ff == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : cfg_base_ff;

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      first     = 1'b0;
      take      = 1'b0;
      take_base = base_ff;
      emit      = 1'b0;
      end_wide  = '0;

      case (phase_ff)
         stip_pkg::PH_WS: begin
            if (stip_pkg::is_space(char_ff)) begin
               phase_in = stip_pkg::PH_WS;
            end else if (char_ff == stip_pkg::CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = stip_pkg::PH_SIGN;
            end else if (char_ff == stip_pkg::CHAR_PLUS) begin
               phase_in = stip_pkg::PH_SIGN;
            end else begin
               first = 1'b1;
            end
         end
         stip_pkg::PH_SIGN: first = 1'b1;
         stip_pkg::PH_ZERO: begin
            if (char_ff == stip_pkg::CHAR_LO_X || char_ff == stip_pkg::CHAR_UP_X) begin
               base_in  = stip_pkg::BASE_HEX;
               phase_in = stip_pkg::PH_HEX;
            end else begin
               take_base = (cfg_base_ff == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_OCT
                                                                : stip_pkg::BASE_HEX;
               base_in   = take_base;
               take      = 1'b1;
            end
         end
         stip_pkg::PH_HEX: begin
            if (dig.valid && dig.value < stip_pkg::BASE_HEX) begin
               take = 1'b1;
            end else begin
               emit     = 1'b1;
               end_wide = EndW'(pos_ff) - EndW'(1);
            end
         end
         stip_pkg::PH_DIGITS: take = 1'b1;
         default: ;
      endcase

      if (first) begin
         if ((cfg_base_ff == stip_pkg::BASE_AUTO || cfg_base_ff == stip_pkg::BASE_HEX) &&
             char_ff == stip_pkg::CHAR_ZERO) begin
            phase_in  = stip_pkg::PH_ZERO;
            status_in = stip_pkg::ST_SEEN;
            acc_in    = '0;
         end else if (first_base < stip_pkg::BASE_MIN || first_base > stip_pkg::BASE_MAX) begin
            emit     = 1'b1;
            end_wide = '0;
         end else begin
            base_in   = first_base;
            take_base = first_base;
            take      = 1'b1;
         end
      end

      if (take) begin
         if (!dig.valid || dig.value >= take_base) begin
            emit     = 1'b1;
            end_wide = EndW'(pos_ff);
         end else begin
            phase_in = stip_pkg::PH_DIGITS;
            if (status_ff != stip_pkg::ST_OVER) begin
               if (over) begin
                  acc_in    = neg_ff ? stip_pkg::SAT_NEG : stip_pkg::SAT_POS;
                  status_in = stip_pkg::ST_OVER;
               end else begin
                  acc_in    = sum[stip_pkg::VALUE_W-1:0];
                  status_in = stip_pkg::ST_SEEN;
               end
            end
         end
      end

      if (emit) phase_in = stip_pkg::PH_DONE;

      if (last_ff && !emit && phase_in != stip_pkg::PH_DONE) begin
         emit     = 1'b1;
         end_wide = (phase_in == stip_pkg::PH_HEX) ? EndW'(pos_ff)
                                                   : EndW'(pos_ff) + EndW'(1);
      end

      out_value_in = '0;
      out_over_in  = 1'b0;
      out_end_in   = '0;
      if (status_in != stip_pkg::ST_NONE) begin
         out_value_in = neg_in ? (stip_pkg::VALUE_W'(0) - acc_in) : acc_in;
         out_over_in  = (status_in == stip_pkg::ST_OVER);
         out_end_in   = end_wide[stip_pkg::END_W-1:0];
      end

      if (last_ff) begin
         phase_in  = stip_pkg::PH_WS;
         status_in = stip_pkg::ST_NONE;
         neg_in    = 1'b0;
         base_in   = '0;
         acc_in    = '0;
         pos_in    = '0;
      end else begin
         pos_in = (pos_ff < PosMax) ? pos_ff + PosW'(1) : PosMax;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.commit && emit) out_valid_in = 1'b1;
   end

   assign sts.emit      = emit;
   assign sts.slot_free = !out_valid_ff || rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_overflow   = out_over_ff;
   assign rsp_end_offset = out_end_ff;

endmodule

### rtl/core/string_to_int64_parser.sv
// string_to_int64_parser: streaming strtoll-style conversion of a byte string to int64.
// Each byte is accepted in the idle state and applied in the execute state before the
// next byte is taken (digit step uses a multiply registered from the state left by the
// previous item); a result is registered when its step commits. A held result stalls
// only when a new result must be written. Reset is synchronous, active high: parse state
// cleared, base_setting set to 10. No clearing pass.
module string_to_int64_parser #(
   parameter int MAX_LEN = 4096
) (
   input logic        clock,
   input logic        reset,
   stip_req_if.sink   req,
   stip_rsp_if.source rsp,
   stip_csr_if.sink   csr
);

   stip_pkg::cmd_type cmd;
   stip_pkg::sts_type sts;

   assign csr.ready = 1'b1;

   stip_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stip_dpath #(
      .MAX_LEN (MAX_LEN)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .char_code      (req.char_code),
      .last           (req.last),
      .csr_write      (csr.valid),
      .csr_data       (csr.data),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_value      (rsp.value),
      .rsp_overflow   (rsp.overflow),
      .rsp_end_offset (rsp.end_offset)
   );

endmodule

### tb/string_to_int64_parser_tb.sv
// string_to_int64_parser_tb: self-checking bench for the streaming string-to-int64 parser.
// Drives byte strings under several base settings and idle patterns, predicts each result.
// Depends on stip_pkg, stip_req_if, stip_rsp_if, stip_csr_if and string_to_int64_parser.
module string_to_int64_parser_tb;
   import stip_pkg::*;

   localparam int MAX_TEXT      = 4096;
   localparam int NO_DIGIT      = 99;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 35;
   localparam int PRESS_BYTES   = 150;
   localparam int PRESS_PHASE   = 4;

   typedef struct {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } text_byte_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      overflow;
      logic [END_W-1:0]          end_offset;
   } number_type;

   logic clock;
   logic reset;

   stip_req_if req_bus ();
   stip_rsp_if rsp_bus ();
   stip_csr_if csr_bus ();

   string_to_int64_parser #(
      .MAX_LEN (MAX_TEXT)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   text_byte_type pending_bytes [$];
   number_type    expected_numbers [$];
   int            pushed_total;
   int            mismatch_count;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            hold_request;
   int            hold_left;
   int            quiet_cycles;
   bit            byte_taken;

   logic [BASE_W-1:0] base_plan [0:9] = '{BASE_AUTO, BASE_HEX, BASE_MIN, BASE_MAX, BASE_OCT,
                                          6'd1, 6'd37, 6'd63, 6'd5, BASE_DEC};

   // parser image
   logic [BASE_W-1:0]  base_reg;
   phase_type          scan_phase;
   logic               minus;
   logic [BASE_W-1:0]  radix;
   logic [VALUE_W-1:0] magnitude;
   status_type         digits_state;
   logic [VALUE_W-1:0] cut_quot;
   logic [BASE_W-1:0]  cut_digit;
   int unsigned        text_pos;

   function automatic int char_digit(input logic [CHAR_W-1:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
      return NO_DIGIT;
   endfunction

   function automatic bit blank_char(input logic [CHAR_W-1:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == " ";
   endfunction

   task automatic clear_text();
      scan_phase   = PH_WS;
      minus        = 1'b0;
      radix        = '0;
      magnitude    = '0;
      digits_state = ST_NONE;
      cut_quot     = '0;
      cut_digit    = '0;
      text_pos     = 0;
   endtask

   task automatic load_radix(input logic [BASE_W-1:0] b);
      logic [VALUE_W-1:0] lim;
      lim       = minus ? SAT_NEG : SAT_POS;
      radix     = b;
      cut_quot  = lim / b;
      cut_digit = BASE_W'(lim % b);
   endtask

   task automatic post_number(input int unsigned at);
      number_type n;
      if (digits_state == ST_NONE) begin
         n = '{value: '0, overflow: 1'b0, end_offset: '0};
      end else begin
         n.value      = minus ? 64'd0 - magnitude : magnitude;
         n.overflow   = (digits_state == ST_OVER);
         n.end_offset = END_W'(at);
      end
      expected_numbers.push_back(n);
      scan_phase = PH_DONE;
   endtask

   task automatic digit_step(input logic [CHAR_W-1:0] c, input int unsigned p,
                             output bit ended);
      int d;
      d     = char_digit(c);
      ended = 1'b0;
      if (d >= int'(radix)) begin
         post_number(p);
         ended = 1'b1;
         return;
      end
      scan_phase = PH_DIGITS;
      if (digits_state == ST_OVER) return;
      if (magnitude > cut_quot || (magnitude == cut_quot && d > int'(cut_digit))) begin
         magnitude    = minus ? SAT_NEG : SAT_POS;
         digits_state = ST_OVER;
      end else begin
         magnitude    = magnitude * radix + 64'(d);
         digits_state = ST_SEEN;
      end
   endtask

   task automatic first_step(input logic [CHAR_W-1:0] c, input int unsigned p,
                             output bit ended);
      logic [BASE_W-1:0] b;
      b     = base_reg;
      ended = 1'b0;
      if ((b == BASE_AUTO || b == BASE_HEX) && c == CHAR_ZERO) begin
         scan_phase   = PH_ZERO;
         digits_state = ST_SEEN;
         magnitude    = '0;
         return;
      end
      if (b == BASE_AUTO) b = BASE_DEC;
      if (b < BASE_MIN || b > BASE_MAX) begin
         post_number(0);
         ended = 1'b1;
         return;
      end
      load_radix(b);
      digit_step(c, p, ended);
   endtask

   task automatic parse_byte(input logic [CHAR_W-1:0] c, input logic lst);
      int unsigned p;
      bit          ended;
      p     = text_pos;
      ended = 1'b0;
      case (scan_phase)
         PH_WS: begin
            if (!blank_char(c)) begin
               if (c == CHAR_MINUS) begin
                  minus      = 1'b1;
                  scan_phase = PH_SIGN;
               end else if (c == CHAR_PLUS) begin
                  scan_phase = PH_SIGN;
               end else begin
                  first_step(c, p, ended);
               end
            end
         end
         PH_SIGN: first_step(c, p, ended);
         PH_ZERO: begin
            if (c == CHAR_LO_X || c == CHAR_UP_X) begin
               load_radix(BASE_HEX);
               scan_phase = PH_HEX;
            end else begin
               load_radix(base_reg == BASE_AUTO ? BASE_OCT : BASE_HEX);
               digit_step(c, p, ended);
            end
         end
         PH_HEX: begin
            if (char_digit(c) < int'(BASE_HEX)) begin
               digit_step(c, p, ended);
            end else begin
               post_number(p - 1);
               ended = 1'b1;
            end
         end
         PH_DIGITS: digit_step(c, p, ended);
         default: ;
      endcase
      if (lst) begin
         if (!ended && scan_phase != PH_DONE) post_number(scan_phase == PH_HEX ? p : p + 1);
         clear_text();
      end else begin
         text_pos = (p < MAX_TEXT) ? p + 1 : MAX_TEXT;
      end
   endtask

   // stimulus helpers
   task automatic push_byte(input logic [CHAR_W-1:0] c, input logic lst);
      pending_bytes.push_back('{char_code: c, last: lst});
      pushed_total++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
   endtask

   task automatic push_random_text();
      logic [CHAR_W-1:0] text [$];
      int n;
      int r;
      int rdx;
      int dv;
      if ($urandom_range(99) < 12) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) push_byte(CHAR_W'($urandom_range(255)), i == n - 1);
         return;
      end
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(6);
         text.push_back(r > 4 ? CHAR_SPACE : CHAR_TAB + CHAR_W'(r));
      end
      r = $urandom_range(3);
      if (r == 0) text.push_back(CHAR_MINUS);
      else if (r == 1) text.push_back(CHAR_PLUS);
      rdx = int'(base_reg);
      r   = $urandom_range(3);
      if (base_reg == BASE_AUTO) begin
         rdx = 10;
         if (r == 0) begin
            text.push_back(CHAR_ZERO);
            rdx = 8;
         end else if (r == 1) begin
            text.push_back(CHAR_ZERO);
            text.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
            rdx = 16;
         end
      end else if (base_reg == BASE_HEX && r == 0) begin
         text.push_back(CHAR_ZERO);
         text.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
      end
      if (rdx < 2 || rdx > 36) rdx = 36;
      n = ($urandom_range(9) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
         dv = $urandom_range(rdx - 1);
         if (dv < 10) text.push_back(CHAR_ZERO + CHAR_W'(dv));
         else if ($urandom_range(1)) text.push_back(CHAR_UP_A + CHAR_W'(dv - 10));
         else text.push_back(CHAR_LO_A + CHAR_W'(dv - 10));
      end
      if ($urandom_range(3) != 0 || text.size() == 0) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) text.push_back(CHAR_W'($urandom_range(255)));
      end
      foreach (text[i]) push_byte(text[i], i == text.size() - 1);
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || expected_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_W-1:0] v);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      base_reg = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idle_mode(input int mode);
      send_idle_pct  = (mode == 1) ? 49 : (mode == 3) ? 30 : 0;
      recv_stall_pct = (mode == 2) ? 49 : (mode == 3) ? 30 : 0;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // byte driver
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         parse_byte(pending_bytes[0].char_code, pending_bytes[0].last);
         void'(pending_bytes.pop_front());
         byte_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || byte_taken) begin
         byte_taken = 1'b0;
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid     <= 1'b1;
            req_bus.char_code <= pending_bytes[0].char_code;
            req_bus.last      <= pending_bytes[0].last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side: random stalls plus one long hold
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      number_type n;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_numbers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected item: value %0d overflow %0b end_offset %0d",
                        rsp_bus.value, rsp_bus.overflow, rsp_bus.end_offset);
         end else begin
            n = expected_numbers.pop_front();
            if (rsp_bus.value !== n.value || rsp_bus.overflow !== n.overflow ||
                rsp_bus.end_offset !== n.end_offset) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: value %0d/%0d overflow %0b/%0b end_offset %0d/%0d (exp/act)",
                           n.value, rsp_bus.value, n.overflow, rsp_bus.overflow,
                           n.end_offset, rsp_bus.end_offset);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL string_to_int64_parser");
            $finish;
         end
      end
   end

   initial begin
      int start;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      pushed_total      = 0;
      mismatch_count    = 0;
      hold_request      = 0;
      hold_left         = 0;
      quiet_cycles      = 0;
      byte_taken        = 1'b0;
      base_reg          = BASE_RESET;
      clear_text();
      set_idle_mode(0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // decimal at reset base: sign, NUL ends number, trailing byte ignored
      push_byte(CHAR_PLUS, 1'b0);
      push_byte("5", 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(CHAR_SPACE, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_text("-");
      wait_idle();

      // auto base: octal, hex, hex prefix without digits
      write_base(BASE_AUTO);
      push_text("010");
      push_text("0x1F");
      push_text("0xg");
      push_text("0X");
      wait_idle();

      write_base(6'd1);
      push_text("7");
      wait_idle();

      for (int k = 0; k < 10; k++) begin
         write_base(base_plan[k]);
         set_idle_mode(k % 4);
         start = pushed_total;
         while (pushed_total - start < (k == PRESS_PHASE ? PRESS_BYTES : PHASE_BYTES))
            push_random_text();
         if (k == PRESS_PHASE) hold_request = HOLD_CYCLES;
         wait_idle();
      end

      if (mismatch_count == 0) $display("PASS string_to_int64_parser");
      else $display("FAIL string_to_int64_parser");
      $finish;
   end

endmodule

### string_to_int64_parser.f
rtl/core/stip_pkg.sv
rtl/core/stip_req_if.sv
rtl/core/stip_rsp_if.sv
rtl/core/stip_csr_if.sv
rtl/core/stip_ctrl.sv
rtl/core/stip_dpath.sv
rtl/core/string_to_int64_parser.sv
tb/string_to_int64_parser_tb.sv
